// File: rtl/hjc_pkg.sv
`default_nettype none

package hjc_pkg;

  localparam logic [15:0] SYL_BASE = 16'hAC00;
  localparam logic [15:0] SYL_LAST = 16'hD7A3;
  localparam logic [15:0] L_BASE   = 16'h1100;
  localparam logic [15:0] L_LAST   = 16'h1112;
  localparam logic [15:0] V_BASE   = 16'h1161;
  localparam logic [15:0] V_LAST   = 16'h1175;
  localparam logic [15:0] T_FIRST  = 16'h11A8;
  localparam logic [15:0] T_LAST   = 16'h11C2;
  localparam logic [15:0] T_BASE   = 16'h11A7;
  localparam logic [15:0] CV_FIRST = 16'h314F;
  localparam logic [15:0] CV_LAST  = 16'h3163;
  localparam logic [15:0] CT_FIRST = 16'h3165;
  localparam logic [15:0] CT_LAST  = 16'h3186;
  localparam logic [15:0] CL_FIRST = 16'h3131;
  localparam logic [15:0] CL_LAST  = 16'h3145;

  localparam logic [15:0] L_STEP = 16'd588;
  localparam logic [15:0] V_STEP = 16'd28;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_VOWEL = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        unit_valid;
    logic        out_last;
  } out_word_t;

  // words handed from the composer to the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  // compatibility leading consonant offset -> {hit, conjoining index}
  function automatic logic [5:0] lead_lookup(input logic [4:0] idx);
    logic [5:0] res;
    res = 6'd0;
    if (idx == 5'd0 || idx == 5'd1) begin
      res = {1'b1, idx};
    end else if (idx == 5'd3) begin
      res = {1'b1, 5'd2};
    end else if (idx >= 5'd6 && idx <= 5'd20) begin
      res = {1'b1, idx - 5'd3};
    end
    return res;
  endfunction

  function automatic logic is_syllable(input logic [15:0] u);
    return (u >= SYL_BASE) && (u <= SYL_LAST);
  endfunction

endpackage

`default_nettype wire

// File: rtl/hjc_core.sv
`default_nettype none

module hjc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire hjc_pkg::in_word_t item_i,
  input  wire logic            syl_only_i,
  output hjc_pkg::push_t       push_o
);
  import hjc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  lead_q, lead_d;
  logic [15:0] base_q, base_d;

  logic [15:0] code, e;
  logic [15:0] cl_off;
  logic [5:0]  lk;
  logic        is_l, is_v, is_t;
  logic [4:0]  l_idx, v_idx, t_val;
  logic [15:0] base_next;
  logic        last;
  logic        idle_path;

  logic        c0_v, c1_v, c2_v;
  logic [15:0] c0_w, c1_w, c2_w;
  logic        k0, k1, k2;
  logic [15:0] wa, wb;
  logic [1:0]  cnt;

  always_comb begin
    code   = item_i.code_unit;
    last   = item_i.last_unit;
    cl_off = code - CL_FIRST;
    lk     = lead_lookup(cl_off[4:0]);

    // compatibility jamo -> conjoining jamo
    if (code >= CL_FIRST && code <= CL_LAST && lk[5]) begin
      e = L_BASE + {11'd0, lk[4:0]};
    end else if (code >= CV_FIRST && code <= CV_LAST) begin
      e = code - (CV_FIRST - V_BASE);
    end else if (code >= CT_FIRST && code <= CT_LAST) begin
      e = code - (CT_FIRST - T_BASE);
    end else begin
      e = code;
    end

    is_l  = (e >= L_BASE) && (e <= L_LAST);
    is_v  = (e >= V_BASE) && (e <= V_LAST);
    is_t  = (e >= T_FIRST) && (e <= T_LAST);
    l_idx = 5'(e - L_BASE);
    v_idx = 5'(e - V_BASE);
    t_val = 5'(e - T_BASE);

    base_next = SYL_BASE + {11'd0, lead_q} * L_STEP + {11'd0, v_idx} * V_STEP;
  end

  always_comb begin
    phase_d   = PH_IDLE;
    lead_d    = lead_q;
    base_d    = base_q;
    idle_path = 1'b0;
    c0_v = 1'b0;  c0_w = '0;
    c1_v = 1'b0;  c1_w = e;
    c2_v = 1'b0;  c2_w = '0;

    // pending jamo against the new unit
    unique case (phase_q)
      PH_LEAD: begin
        if (is_v) begin
          phase_d = PH_VOWEL;
          base_d  = base_next;
        end else begin
          c0_v      = 1'b1;
          c0_w      = L_BASE + {11'd0, lead_q};
          idle_path = 1'b1;
        end
      end
      PH_VOWEL: begin
        c0_v      = 1'b1;
        c0_w      = base_q + (is_t ? {11'd0, t_val} : 16'd0);
        idle_path = !is_t;
      end
      default: idle_path = 1'b1;
    endcase

    if (idle_path) begin
      if (is_l) begin
        phase_d = PH_LEAD;
        lead_d  = l_idx;
      end else begin
        c1_v = 1'b1;
      end
    end

    // end of string flushes whatever is still held
    if (last) begin
      if (phase_d == PH_LEAD) begin
        c2_v = 1'b1;
        c2_w = L_BASE + {11'd0, lead_d};
      end else if (phase_d == PH_VOWEL) begin
        c2_v = 1'b1;
        c2_w = base_next;
      end
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    k0 = c0_v && !(syl_only_i && !is_syllable(c0_w));
    k1 = c1_v && !(syl_only_i && !is_syllable(c1_w));
    k2 = c2_v && !(syl_only_i && !is_syllable(c2_w));
    cnt = 2'({1'b0, k0} + {1'b0, k1} + {1'b0, k2});

    priority if (k0) begin
      wa = c0_w;
      wb = k1 ? c1_w : c2_w;
    end else if (k1) begin
      wa = c1_w;
      wb = c2_w;
    end else begin
      wa = c2_w;
      wb = '0;
    end

    push_o.w0 = '{out_unit: wa, unit_valid: 1'b1, out_last: last && (cnt == 2'd1)};
    push_o.w1 = '{out_unit: wb, unit_valid: 1'b1, out_last: last};
    push_o.count = cnt;
    if (cnt == 2'd0 && last) begin
      // nothing left of the last unit: end-of-string marker only
      push_o.w0    = '{out_unit: 16'd0, unit_valid: 1'b0, out_last: 1'b1};
      push_o.count = 2'd1;
    end
    if (!take_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (take_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      lead_q <= lead_d;
      base_q <= base_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hangul_jamo_composer.sv
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-------------------------------
// in       | input     | in_valid_i / in_ready_o    | in_word_i  {code_unit, last_unit}
// out      | output    | out_valid_o / out_ready_i  | out_word_o {out_unit, unit_valid,
//          |           |                            |             out_last}
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i {syllables_only}
//
// An item yields at most two words. A new item is taken from the input register
// only while the output queue holds at most one word; the queue drains one word
// per cycle while out_ready_i is high.
// Reset clears control state only; there is no clearing pass.
// A stall on the output backs up into the 3-word queue, then into the input
// register; the input side never waits on out_ready_i combinationally.
`default_nettype none

module hangul_jamo_composer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hjc_pkg::in_word_t in_word_i,

  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hjc_pkg::out_word_t     out_word_o,

  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i
);
  import hjc_pkg::*;

  // input register
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     take;

  // mode register
  logic syl_only_q;

  // output queue: entry 0 is the head
  out_word_t q_q [3];
  out_word_t q_d [3];
  logic [1:0] q_count_q, q_count_d;
  logic [1:0] base_idx;
  logic       pop;
  push_t      push;

  // room for two words without looking at out_ready_i
  assign take       = in_valid_q && (q_count_q <= 2'd1);
  assign in_ready_o = !in_valid_q || take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syl_only_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      syl_only_q <= cfg_data_i;
    end
  end

  // expansion, pairing and syllable build
  hjc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (in_word_q),
    .syl_only_i (syl_only_q),
    .push_o     (push)
  );

  assign out_valid_o = (q_count_q != 2'd0);
  assign out_word_o  = q_q[0];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    base_idx = q_count_q - {1'b0, pop};
    // shift out the head on pop
    q_d[0] = pop ? q_q[1] : q_q[0];
    q_d[1] = pop ? q_q[2] : q_q[1];
    q_d[2] = q_q[2];
    // append pushed words behind what stays
    for (int i = 0; i < 3; i++) begin
      if (push.count != 2'd0 && base_idx == 2'(i)) begin
        q_d[i] = push.w0;
      end
      if (push.count == 2'd2 && 2'(base_idx + 2'd1) == 2'(i)) begin
        q_d[i] = push.w1;
      end
    end
    q_count_d = base_idx + push.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_count_q <= 2'd0;
    end else begin
      q_count_q <= q_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= q_d[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/hjc_checker.sv
`default_nettype none

module hjc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire hjc_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire hjc_pkg::out_word_t out_word_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic               cfg_data_i
);
  import hjc_pkg::*;

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.unit_valid |->
      out_word_o.out_last && out_word_o.out_unit == 16'd0)
    else $error("end marker without out_last or with nonzero unit");

  a_syl_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.unit_valid && mode_q |-> is_syllable(out_word_o.out_unit))
    else $error("non-syllable word in syllables-only mode");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind hangul_jamo_composer hjc_checker u_hjc_checker (.*);

`default_nettype wire
